>>> sv/fcpa_pkg.sv
// Shared types and constants for the fixed chunk pool allocator.
// No dependencies.
package fcpa_pkg;

  // Effective chunk size width: up to 8191 bytes rounded to 2^15.
  localparam int unsigned EffW = 17;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_ALIGN = 3'd1,
    STAT_TOO_LARGE = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_DISABLED  = 3'd4,
    STAT_FREE_IGN  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_CHUNK_SIZE   = 2'd1,
    CFG_ALIGN_LOG2   = 2'd2,
    CFG_CHUNK_COUNT  = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_RESP  = 3'b100
  } state_e;

endpackage

>>> sv/fcpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcpa_ram #(
  parameter int unsigned Width = 9,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/fcpa_mul.sv
// Shared multiplier with registered product: chunk offset and pool extent.
// No dependencies.
module fcpa_mul #(
  parameter int unsigned AW = 9,
  parameter int unsigned BW = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] prod_o
);

  logic [AW+BW-1:0] prod_q, prod_d;

  assign prod_d = (AW + BW)'(a_i) * (AW + BW)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> sv/fixed_chunk_pool_allocator_unit.sv
// Top level of the fixed chunk pool allocator: sequencer, registers, list head.
// Depends on fcpa_pkg, fcpa_ram and fcpa_mul.
//
// Usage:
//   Request channel: drive action and its fields with start high; a request is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: done_o pulses for one cycle with status, granted index and
//   address and the ownership flag. The receiver cannot stall; a result not
//   sampled in its cycle is gone.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i.
//   Ready is always high; write only while the block is idle.
// Timing:
//   Alloc, free, query and rejected requests: the result strobe follows the
//   ST_RESP step, and the next request is accepted in the same cycle as the
//   strobe. The shared multiplier and the registered read of the link memory
//   make that response step necessary.
//   Clear on an enabled pool: the sequencer writes one link per cycle, then
//   passes through ST_RESP to its result; count_eff = min(count, max) links.
// Reset:
//   Free list empty, registers at their reset values, link memory undefined.
//   Issue a clear after configuring before the first alloc.
module fixed_chunk_pool_allocator_unit #(
  parameter int unsigned MAX_CHUNKS    = 256,
  parameter int unsigned POINTER_BYTES = 8,
  parameter int unsigned ADDRESS_BITS  = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  fcpa_pkg::cfg_index_e    cfg_index_i,
  input  logic [ADDRESS_BITS-1:0] cfg_data_i,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  fcpa_pkg::action_e       action_i,
  input  logic [15:0]             req_size_i,
  input  logic [15:0]             req_align_i,
  input  logic [7:0]              chunk_index_i,
  input  logic [ADDRESS_BITS-1:0] query_address_i,
  // result strobe
  output logic                    done_o,
  output fcpa_pkg::status_e       status_o,
  output logic [7:0]              granted_index_o,
  output logic [ADDRESS_BITS-1:0] granted_address_o,
  output logic                    owned_o
);

  import fcpa_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_CHUNKS);
  localparam int unsigned CntW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned PW   = CntW + EffW;
  localparam int unsigned DW   = (ADDRESS_BITS > PW) ? ADDRESS_BITS : PW;
  localparam int unsigned LinkW = IdxW + 1;

  // ---------------- configuration registers ----------------
  logic [ADDRESS_BITS-1:0] base_q;
  logic [12:0]             csize_q;
  logic [3:0]              align_q;
  logic [8:0]              ccount_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      csize_q  <= '0;
      align_q  <= 4'd3;
      ccount_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BASE_ADDRESS: base_q   <= cfg_data_i;
        CFG_CHUNK_SIZE:   csize_q  <= cfg_data_i[12:0];
        CFG_ALIGN_LOG2:   align_q  <= cfg_data_i[3:0];
        CFG_CHUNK_COUNT:  ccount_q <= cfg_data_i[8:0];
        default:          ;
      endcase
    end
  end

  // Pool geometry from config only; user keeps it stable while busy, unenforced.
  logic [EffW-1:0] size_floor, align_val, eff_size;
  logic [CntW-1:0] count_eff;
  logic            pool_en;

  assign size_floor = (EffW'(csize_q) < EffW'(POINTER_BYTES)) ? EffW'(POINTER_BYTES)
                                                              : EffW'(csize_q);
  assign align_val  = EffW'(1) << align_q;
  assign eff_size   = (size_floor + align_val - EffW'(1)) & ~(align_val - EffW'(1));
  assign count_eff  = (32'(ccount_q) > MAX_CHUNKS) ? CntW'(MAX_CHUNKS) : CntW'(ccount_q);
  assign pool_en    = (csize_q != '0) && (ccount_q != '0);

  // ---------------- sequencer state ----------------
  state_e                  state_q, state_d;
  logic [IdxW-1:0]         head_q, head_d;
  logic                    head_vld_q, head_vld_d;
  logic [CntW-1:0]         clr_q, clr_d;
  status_e                 pend_stat_q, pend_stat_d;
  logic                    pop_q, pop_d;
  logic                    qry_q, qry_d;
  logic                    ge_q, ge_d;
  logic [ADDRESS_BITS-1:0] diff_q, diff_d;

  logic accept;
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // link memory ports
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [LinkW-1:0] ram_wdata, ram_rdata;

  // shared multiplier ports
  logic            mul_en;
  logic [CntW-1:0] mul_a;
  logic [PW-1:0]   mul_prod;

  // request checks
  logic            align_bad, too_large, free_ok;
  logic [CntW-1:0] clr_next;

  assign align_bad = (req_align_i == '0) || ((req_align_i & (req_align_i - 16'd1)) != '0);
  assign too_large = (req_size_i == '0) || (EffW'(req_size_i) > eff_size)
                     || (EffW'(req_align_i) > align_val);
  assign free_ok   = pool_en && (32'(chunk_index_i) < 32'(count_eff));
  assign clr_next  = clr_q + CntW'(1);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    head_vld_d  = head_vld_q;
    clr_d       = clr_q;
    pend_stat_d = pend_stat_q;
    pop_d       = pop_q;
    qry_d       = qry_q;
    ge_d        = ge_q;
    diff_d      = diff_q;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_wdata   = {head_vld_q, head_q};
    mul_en      = 1'b0;
    mul_a       = CntW'(head_q);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d     = ST_RESP;
          pend_stat_d = STAT_OK;
          pop_d       = 1'b0;
          qry_d       = 1'b0;
          case (action_i)
            ACT_ALLOC: begin
              if (align_bad) begin
                pend_stat_d = STAT_BAD_ALIGN;
              end else if (!pool_en) begin
                pend_stat_d = STAT_DISABLED;
              end else if (too_large) begin
                pend_stat_d = STAT_TOO_LARGE;
              end else if (!head_vld_q) begin
                pend_stat_d = STAT_EMPTY;
              end else begin
                // head offset; link read of head lands next cycle
                pop_d  = 1'b1;
                mul_en = 1'b1;
                mul_a  = CntW'(head_q);
              end
            end
            ACT_FREE: begin
              if (free_ok) begin
                ram_we     = 1'b1;
                ram_waddr  = IdxW'(chunk_index_i);
                ram_wdata  = {head_vld_q, head_q};
                head_d     = IdxW'(chunk_index_i);
                head_vld_d = 1'b1;
              end else begin
                pend_stat_d = STAT_FREE_IGN;
              end
            end
            ACT_CLEAR: begin
              if (pool_en) begin
                state_d = ST_CLEAR;
                clr_d   = '0;
              end else begin
                pend_stat_d = STAT_DISABLED;
              end
            end
            default: begin
              // ownership query: region extent through the multiplier
              qry_d  = pool_en;
              ge_d   = (query_address_i >= base_q);
              diff_d = query_address_i - base_q;
              mul_en = 1'b1;
              mul_a  = count_eff;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        // relink chunk i -> i+1, last one ends the list
        ram_we    = 1'b1;
        ram_waddr = clr_q[IdxW-1:0];
        ram_wdata = {(clr_next < count_eff), clr_next[IdxW-1:0]};
        clr_d     = clr_next;
        if (clr_next == count_eff) begin
          state_d    = ST_RESP;
          head_d     = '0;
          head_vld_d = 1'b1;
        end
      end
      ST_RESP: begin
        state_d = ST_IDLE;
        if (pop_q) begin
          head_d     = ram_rdata[IdxW-1:0];
          head_vld_d = ram_rdata[IdxW];
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      head_vld_q  <= 1'b0;
      clr_q       <= '0;
      pend_stat_q <= STAT_OK;
      pop_q       <= 1'b0;
      qry_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      head_vld_q  <= head_vld_d;
      clr_q       <= clr_d;
      pend_stat_q <= pend_stat_d;
      pop_q       <= pop_d;
      qry_q       <= qry_d;
    end
  end

  // query operands need no reset
  always_ff @(posedge clk_i) begin
    ge_q   <= ge_d;
    diff_q <= diff_d;
  end

  fcpa_ram #(
    .Width (LinkW),
    .Depth (MAX_CHUNKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  fcpa_mul #(
    .AW (CntW),
    .BW (EffW)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (eff_size),
    .prod_o (mul_prod)
  );

  // ---------------- result register ----------------
  logic [DW-1:0] addr_sum;
  logic          owned_d;

  assign addr_sum = DW'(base_q) + DW'(mul_prod);
  assign owned_d  = qry_q && ge_q && (DW'(diff_q) < DW'(mul_prod));

  logic done_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == ST_RESP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP) begin
      status_o          <= pend_stat_q;
      granted_index_o   <= pop_q ? 8'(head_q) : 8'd0;
      granted_address_o <= pop_q ? addr_sum[ADDRESS_BITS-1:0] : '0;
      owned_o           <= owned_d;
    end
  end

  // ---------------- assertions ----------------
  // a result strobe lands in an idle cycle, right after the response step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(state_q == ST_RESP)))
    else $error("result strobe outside response slot");

  // every accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("request accepted without going busy");

  // ownership is only reported with an ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && owned_o) |-> (status_o == STAT_OK))
    else $error("owned flag with error status");

  // a clear always leaves a non-empty list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && state_d == ST_RESP) |=> head_vld_q)
    else $error("clear left the free list empty");

endmodule
